// File: rtl/core/rvie_pkg.sv
// Shared operation codes, control types and constants for the RV32I execute stage.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package rvie_pkg;

   // Operation codes of an incoming transaction
   localparam logic [4:0] OP_ADD   = 5'd0;
   localparam logic [4:0] OP_SUB   = 5'd1;
   localparam logic [4:0] OP_ADDI  = 5'd2;
   localparam logic [4:0] OP_AND   = 5'd3;
   localparam logic [4:0] OP_OR    = 5'd4;
   localparam logic [4:0] OP_XOR   = 5'd5;
   localparam logic [4:0] OP_ANDI  = 5'd6;
   localparam logic [4:0] OP_ORI   = 5'd7;
   localparam logic [4:0] OP_XORI  = 5'd8;
   localparam logic [4:0] OP_SLLI  = 5'd9;
   localparam logic [4:0] OP_SRLI  = 5'd10;
   localparam logic [4:0] OP_SRAI  = 5'd11;
   localparam logic [4:0] OP_SLT   = 5'd12;
   localparam logic [4:0] OP_SLTI  = 5'd13;
   localparam logic [4:0] OP_SLTU  = 5'd14;
   localparam logic [4:0] OP_SLTIU = 5'd15;
   localparam logic [4:0] OP_LUI   = 5'd16;
   localparam logic [4:0] OP_AUIPC = 5'd17;
   localparam logic [4:0] OP_LW    = 5'd18;
   localparam logic [4:0] OP_SW    = 5'd19;
   localparam logic [4:0] OP_BEQ   = 5'd20;
   localparam logic [4:0] OP_BNE   = 5'd21;
   localparam logic [4:0] OP_BLT   = 5'd22;
   localparam logic [4:0] OP_BGE   = 5'd23;
   localparam logic [4:0] OP_BLTU  = 5'd24;
   localparam logic [4:0] OP_BGEU  = 5'd25;
   localparam logic [4:0] OP_JAL   = 5'd26;
   localparam logic [4:0] OP_JALR  = 5'd27;
   localparam logic [4:0] OP_NOP   = 5'd28;

   localparam int unsigned XLEN    = 32;
   localparam int unsigned SHAMT_W = 5;
   localparam logic [XLEN-1:0] LINK_STEP = 32'd4;

   typedef logic [XLEN-1:0] word_type;

   // ALU function selected by the decoder
   typedef enum logic [3:0] {
      FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_SLL, FN_SRL, FN_SRA,
      FN_SLT, FN_SLTU, FN_PASS_B, FN_ZERO
   } alu_fn_type;

   // Branch condition selected by the decoder
   typedef enum logic [2:0] {
      BR_NONE, BR_EQ, BR_NE, BR_LT, BR_GE, BR_LTU, BR_GEU, BR_ALWAYS
   } br_cond_type;

   // Decode -> execute control
   typedef struct packed {
      alu_fn_type  alu_fn;
      logic        use_imm;
      logic        a_is_pc;
      br_cond_type br_cond;
      logic        jalr;
      logic        link;
      logic        mem_read;
      logic        mem_write;
      logic        bad;
   } ctrl_type;

   // Execute -> result control
   typedef struct packed {
      logic link;
      logic taken;
      logic mem_read;
      logic mem_write;
      logic bad;
   } wb_type;

endpackage

// File: rtl/core/rv32i_integer_execute.sv
// Top level of the RV32I integer execute stage: decode, execute and result stages.
// Depends on rvie_pkg, rvie_decode, rvie_alu and rvie_result.
//
//   channel   handshake            payload ports
//   request   start / busy         req_type, req_instr_pc, req_rs1_value,
//                                  req_rs2_value, req_immediate
//   response  rsp_valid (strobe)   rsp_alu_result .. rsp_bad_operation
//
// Three register stages (decode, ALU and adders, result select) lie between
// an accepted start and the rsp_valid strobe.
// A new transaction is taken every cycle; busy is held low.
// The response strobe lasts one cycle and is never held off.
// Synchronous reset clears the valid bits of all three stages.
module rv32i_integer_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [4:0]  req_type,
   input  logic [31:0] req_instr_pc,
   input  logic [31:0] req_rs1_value,
   input  logic [31:0] req_rs2_value,
   input  logic signed [31:0] req_immediate,
   output logic        rsp_valid,
   output logic [31:0] rsp_alu_result,
   output logic        rsp_redirect,
   output logic [31:0] rsp_redirect_target,
   output logic        rsp_mem_read,
   output logic        rsp_mem_write,
   output logic [31:0] rsp_mem_address,
   output logic [31:0] rsp_store_data,
   output logic        rsp_bad_operation
);

   logic               accept;
   logic               dec_valid, exe_valid;
   rvie_pkg::ctrl_type dec_ctrl;
   rvie_pkg::wb_type   exe_wb;
   rvie_pkg::word_type dec_pc, dec_rs1, dec_rs2, dec_imm, dec_opb;
   rvie_pkg::word_type exe_alu, exe_link, exe_target, exe_addr, exe_store;

   // Pipeline takes a transaction every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   rvie_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .op        (req_type),
      .pc        (req_instr_pc),
      .rs1       (req_rs1_value),
      .rs2       (req_rs2_value),
      .imm       (rvie_pkg::word_type'(req_immediate)),
      .out_valid (dec_valid),
      .out_ctrl  (dec_ctrl),
      .out_pc    (dec_pc),
      .out_rs1   (dec_rs1),
      .out_rs2   (dec_rs2),
      .out_imm   (dec_imm),
      .out_opb   (dec_opb)
   );

   rvie_alu u_alu (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dec_valid),
      .ctrl       (dec_ctrl),
      .pc         (dec_pc),
      .rs1        (dec_rs1),
      .rs2        (dec_rs2),
      .imm        (dec_imm),
      .opb        (dec_opb),
      .out_valid  (exe_valid),
      .out_wb     (exe_wb),
      .out_alu    (exe_alu),
      .out_link   (exe_link),
      .out_target (exe_target),
      .out_addr   (exe_addr),
      .out_store  (exe_store)
   );

   rvie_result u_result (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (exe_valid),
      .wb            (exe_wb),
      .alu           (exe_alu),
      .link          (exe_link),
      .target        (exe_target),
      .addr          (exe_addr),
      .store         (exe_store),
      .out_valid     (rsp_valid),
      .out_result    (rsp_alu_result),
      .out_redirect  (rsp_redirect),
      .out_target    (rsp_redirect_target),
      .out_mem_read  (rsp_mem_read),
      .out_mem_write (rsp_mem_write),
      .out_addr      (rsp_mem_address),
      .out_store     (rsp_store_data),
      .out_bad       (rsp_bad_operation)
   );

`ifndef NO_ASSERTIONS
   // Every response comes from a matching accepted transaction
   a_resp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("response without a matching request");

   // A bad code makes no request, no redirect and no destination value
   a_bad_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_operation) |->
         (!rsp_redirect && !rsp_mem_read && !rsp_mem_write && rsp_alu_result == '0))
      else $error("bad operation produced side effects");

   // Load and store never both requested
   a_mem_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_mem_read && rsp_mem_write))
      else $error("load and store at once");

   // Load address is rs1 plus immediate of the matching request
   a_load_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mem_read) |->
         (rsp_mem_address == $past(req_rs1_value + req_immediate, 3)))
      else $error("load address mismatch");
`endif

endmodule

// File: rtl/core/rvie_decode.sv
// Stage 1: decode the operation code and register the operands.
// Depends on rvie_pkg.
module rvie_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [4:0]               op,
   input  rvie_pkg::word_type       pc,
   input  rvie_pkg::word_type       rs1,
   input  rvie_pkg::word_type       rs2,
   input  rvie_pkg::word_type       imm,
   output logic                     out_valid,
   output rvie_pkg::ctrl_type       out_ctrl,
   output rvie_pkg::word_type       out_pc,
   output rvie_pkg::word_type       out_rs1,
   output rvie_pkg::word_type       out_rs2,
   output rvie_pkg::word_type       out_imm,
   output rvie_pkg::word_type       out_opb
);

   logic               valid_ff;
   rvie_pkg::ctrl_type ctrl_in, ctrl_ff;
   rvie_pkg::word_type pc_ff, rs1_ff, rs2_ff, imm_ff, opb_ff, opb_in;

   // Translate the operation code into control fields
   always_comb begin
      ctrl_in           = '0;
      ctrl_in.alu_fn    = rvie_pkg::FN_ZERO;
      ctrl_in.br_cond   = rvie_pkg::BR_NONE;
      unique case (op)
         rvie_pkg::OP_ADD:   ctrl_in.alu_fn = rvie_pkg::FN_ADD;
         rvie_pkg::OP_SUB:   ctrl_in.alu_fn = rvie_pkg::FN_SUB;
         rvie_pkg::OP_AND:   ctrl_in.alu_fn = rvie_pkg::FN_AND;
         rvie_pkg::OP_OR:    ctrl_in.alu_fn = rvie_pkg::FN_OR;
         rvie_pkg::OP_XOR:   ctrl_in.alu_fn = rvie_pkg::FN_XOR;
         rvie_pkg::OP_SLT:   ctrl_in.alu_fn = rvie_pkg::FN_SLT;
         rvie_pkg::OP_SLTU:  ctrl_in.alu_fn = rvie_pkg::FN_SLTU;
         rvie_pkg::OP_ADDI: begin
            ctrl_in.alu_fn  = rvie_pkg::FN_ADD;
            ctrl_in.use_imm = 1'b1;
         end
         rvie_pkg::OP_ANDI: begin
            ctrl_in.alu_fn  = rvie_pkg::FN_AND;
            ctrl_in.use_imm = 1'b1;
         end
         rvie_pkg::OP_ORI: begin
            ctrl_in.alu_fn  = rvie_pkg::FN_OR;
            ctrl_in.use_imm = 1'b1;
         end
         rvie_pkg::OP_XORI: begin
            ctrl_in.alu_fn  = rvie_pkg::FN_XOR;
            ctrl_in.use_imm = 1'b1;
         end
         rvie_pkg::OP_SLLI: begin
            ctrl_in.alu_fn  = rvie_pkg::FN_SLL;
            ctrl_in.use_imm = 1'b1;
         end
         rvie_pkg::OP_SRLI: begin
            ctrl_in.alu_fn  = rvie_pkg::FN_SRL;
            ctrl_in.use_imm = 1'b1;
         end
         rvie_pkg::OP_SRAI: begin
            ctrl_in.alu_fn  = rvie_pkg::FN_SRA;
            ctrl_in.use_imm = 1'b1;
         end
         rvie_pkg::OP_SLTI: begin
            ctrl_in.alu_fn  = rvie_pkg::FN_SLT;
            ctrl_in.use_imm = 1'b1;
         end
         rvie_pkg::OP_SLTIU: begin
            ctrl_in.alu_fn  = rvie_pkg::FN_SLTU;
            ctrl_in.use_imm = 1'b1;
         end
         rvie_pkg::OP_LUI: begin
            ctrl_in.alu_fn  = rvie_pkg::FN_PASS_B;
            ctrl_in.use_imm = 1'b1;
         end
         rvie_pkg::OP_AUIPC: begin
            ctrl_in.alu_fn  = rvie_pkg::FN_ADD;
            ctrl_in.use_imm = 1'b1;
            ctrl_in.a_is_pc = 1'b1;
         end
         rvie_pkg::OP_LW:    ctrl_in.mem_read  = 1'b1;
         rvie_pkg::OP_SW:    ctrl_in.mem_write = 1'b1;
         rvie_pkg::OP_BEQ:   ctrl_in.br_cond   = rvie_pkg::BR_EQ;
         rvie_pkg::OP_BNE:   ctrl_in.br_cond   = rvie_pkg::BR_NE;
         rvie_pkg::OP_BLT:   ctrl_in.br_cond   = rvie_pkg::BR_LT;
         rvie_pkg::OP_BGE:   ctrl_in.br_cond   = rvie_pkg::BR_GE;
         rvie_pkg::OP_BLTU:  ctrl_in.br_cond   = rvie_pkg::BR_LTU;
         rvie_pkg::OP_BGEU:  ctrl_in.br_cond   = rvie_pkg::BR_GEU;
         rvie_pkg::OP_JAL: begin
            ctrl_in.br_cond = rvie_pkg::BR_ALWAYS;
            ctrl_in.link    = 1'b1;
         end
         rvie_pkg::OP_JALR: begin
            ctrl_in.br_cond = rvie_pkg::BR_ALWAYS;
            ctrl_in.link    = 1'b1;
            ctrl_in.jalr    = 1'b1;
         end
         rvie_pkg::OP_NOP: ;
         default:          ctrl_in.bad = 1'b1;
      endcase
   end

   // Pick the second ALU operand
   assign opb_in = ctrl_in.use_imm ? imm : rs2;

   // Advance the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Hold the payload of the transaction
   always_ff @(posedge clock) begin
      ctrl_ff <= ctrl_in;
      pc_ff   <= pc;
      rs1_ff  <= rs1;
      rs2_ff  <= rs2;
      imm_ff  <= imm;
      opb_ff  <= opb_in;
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_pc    = pc_ff;
   assign out_rs1   = rs1_ff;
   assign out_rs2   = rs2_ff;
   assign out_imm   = imm_ff;
   assign out_opb   = opb_ff;

endmodule

// File: rtl/core/rvie_alu.sv
// Stage 2: ALU, shifter, branch compare and address adders.
// Depends on rvie_pkg.
module rvie_alu (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  rvie_pkg::ctrl_type       ctrl,
   input  rvie_pkg::word_type       pc,
   input  rvie_pkg::word_type       rs1,
   input  rvie_pkg::word_type       rs2,
   input  rvie_pkg::word_type       imm,
   input  rvie_pkg::word_type       opb,
   output logic                     out_valid,
   output rvie_pkg::wb_type         out_wb,
   output rvie_pkg::word_type       out_alu,
   output rvie_pkg::word_type       out_link,
   output rvie_pkg::word_type       out_target,
   output rvie_pkg::word_type       out_addr,
   output rvie_pkg::word_type       out_store
);

   logic                          valid_ff;
   rvie_pkg::wb_type              wb_in, wb_ff;
   rvie_pkg::word_type            opa, alu_in, alu_ff, link_ff, target_in, target_ff;
   rvie_pkg::word_type            addr_in, addr_ff, store_ff, jalr_sum;
   logic [rvie_pkg::SHAMT_W-1:0]  shamt;
   logic                          lt_s, lt_u, br_eq, br_lt_s, br_lt_u, taken;

   assign opa   = ctrl.a_is_pc ? pc : rs1;
   assign shamt = opb[rvie_pkg::SHAMT_W-1:0];
   assign lt_s  = $signed(rs1) < $signed(opb);
   assign lt_u  = rs1 < opb;

   // ALU function
   always_comb begin
      case (ctrl.alu_fn)
         rvie_pkg::FN_ADD:    alu_in = opa + opb;
         rvie_pkg::FN_SUB:    alu_in = opa - opb;
         rvie_pkg::FN_AND:    alu_in = opa & opb;
         rvie_pkg::FN_OR:     alu_in = opa | opb;
         rvie_pkg::FN_XOR:    alu_in = opa ^ opb;
         rvie_pkg::FN_SLL:    alu_in = opa << shamt;
         rvie_pkg::FN_SRL:    alu_in = opa >> shamt;
         rvie_pkg::FN_SRA:    alu_in = rvie_pkg::word_type'($signed(opa) >>> shamt);
         rvie_pkg::FN_SLT:    alu_in = {{(rvie_pkg::XLEN-1){1'b0}}, lt_s};
         rvie_pkg::FN_SLTU:   alu_in = {{(rvie_pkg::XLEN-1){1'b0}}, lt_u};
         rvie_pkg::FN_PASS_B: alu_in = opb;
         default:             alu_in = '0;
      endcase
   end

   // Branch condition on the two register values
   assign br_eq   = rs1 == rs2;
   assign br_lt_s = $signed(rs1) < $signed(rs2);
   assign br_lt_u = rs1 < rs2;

   always_comb begin
      case (ctrl.br_cond)
         rvie_pkg::BR_EQ:     taken = br_eq;
         rvie_pkg::BR_NE:     taken = !br_eq;
         rvie_pkg::BR_LT:     taken = br_lt_s;
         rvie_pkg::BR_GE:     taken = !br_lt_s;
         rvie_pkg::BR_LTU:    taken = br_lt_u;
         rvie_pkg::BR_GEU:    taken = !br_lt_u;
         rvie_pkg::BR_ALWAYS: taken = 1'b1;
         default:             taken = 1'b0;
      endcase
   end

   // Target and memory address adders; JALR drops bit zero
   assign addr_in   = rs1 + imm;
   assign jalr_sum  = addr_in;
   assign target_in = ctrl.jalr ? {jalr_sum[rvie_pkg::XLEN-1:1], 1'b0} : pc + imm;

   always_comb begin
      wb_in           = '0;
      wb_in.link      = ctrl.link;
      wb_in.taken     = taken;
      wb_in.mem_read  = ctrl.mem_read;
      wb_in.mem_write = ctrl.mem_write;
      wb_in.bad       = ctrl.bad;
   end

   // Advance the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      wb_ff     <= wb_in;
      alu_ff    <= alu_in;
      link_ff   <= pc + rvie_pkg::LINK_STEP;
      target_ff <= target_in;
      addr_ff   <= addr_in;
      store_ff  <= rs2;
   end

   assign out_valid  = valid_ff;
   assign out_wb     = wb_ff;
   assign out_alu    = alu_ff;
   assign out_link   = link_ff;
   assign out_target = target_ff;
   assign out_addr   = addr_ff;
   assign out_store  = store_ff;

endmodule

// File: rtl/core/rvie_result.sv
// Stage 3: select the destination value, gate unused fields and register the result.
// Depends on rvie_pkg.
module rvie_result (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  rvie_pkg::wb_type         wb,
   input  rvie_pkg::word_type       alu,
   input  rvie_pkg::word_type       link,
   input  rvie_pkg::word_type       target,
   input  rvie_pkg::word_type       addr,
   input  rvie_pkg::word_type       store,
   output logic                     out_valid,
   output rvie_pkg::word_type       out_result,
   output logic                     out_redirect,
   output rvie_pkg::word_type       out_target,
   output logic                     out_mem_read,
   output logic                     out_mem_write,
   output rvie_pkg::word_type       out_addr,
   output rvie_pkg::word_type       out_store,
   output logic                     out_bad
);

   logic               valid_ff, redirect_ff, mem_read_ff, mem_write_ff, bad_ff;
   rvie_pkg::word_type result_ff, target_ff, addr_ff, store_ff;
   logic               is_mem;

   assign is_mem = wb.mem_read | wb.mem_write;

   // Advance the strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Zero the target, address and store fields when the operation does not produce them
   always_ff @(posedge clock) begin
      result_ff    <= wb.link ? link : alu;
      redirect_ff  <= wb.taken;
      target_ff    <= wb.taken ? target : '0;
      mem_read_ff  <= wb.mem_read;
      mem_write_ff <= wb.mem_write;
      addr_ff      <= is_mem ? addr : '0;
      store_ff     <= wb.mem_write ? store : '0;
      bad_ff       <= wb.bad;
   end

   assign out_valid     = valid_ff;
   assign out_result    = result_ff;
   assign out_redirect  = redirect_ff;
   assign out_target    = target_ff;
   assign out_mem_read  = mem_read_ff;
   assign out_mem_write = mem_write_ff;
   assign out_addr      = addr_ff;
   assign out_store     = store_ff;
   assign out_bad       = bad_ff;

endmodule
